[hw/rtl/ecal_pkg.sv]
// Shared constants, field widths and sizing functions for the epoch-to-calendar block.
// No dependencies; imported by every module of the block.

package ecal_pkg;

    // Time and calendar constants
    localparam longint unsigned MS_PER_SEC     = 64'd1000;
    localparam longint unsigned SEC_PER_MIN    = 64'd60;
    localparam longint unsigned SEC_PER_HOUR   = 64'd3600;
    localparam longint unsigned SEC_PER_DAY    = 64'd86400;
    localparam longint unsigned MS_PER_DAY     = 64'd86400000;
    localparam longint unsigned DAYS_TO_1970   = 64'd719528;
    localparam longint unsigned DAYS_PER_400Y  = 64'd146097;
    localparam longint unsigned DAYS_PER_100Y  = 64'd36524;
    localparam longint unsigned DAYS_PER_4Y    = 64'd1461;
    localparam longint unsigned DAYS_PER_YEAR  = 64'd365;
    localparam longint unsigned YEARS_PER_ERA  = 64'd400;
    localparam longint unsigned YEARS_PER_CENT = 64'd100;

    // Quotient bits resolved per divider stage
    localparam int DIV_BPS = 4;

    // Reciprocal for x / 1461, exact for x <= 36524
    localparam longint unsigned Q4Y_MUL   = 64'd45934;
    localparam int              Q4Y_SHIFT = 26;

    // Result field widths
    localparam int YEAR_W = 16;
    localparam int MON_W  = 4;
    localparam int MDAY_W = 5;
    localparam int HOUR_W = 5;
    localparam int MIN_W  = 6;
    localparam int SEC_W  = 6;
    localparam int MSEC_W = 10;
    localparam int TOD_W  = MSEC_W + HOUR_W + MIN_W + SEC_W;

    // Internal widths
    localparam int SOD_W  = $clog2(SEC_PER_DAY);        // second of day
    localparam int DOFS_W = $clog2(DAYS_TO_1970 + 1);   // epoch day offset
    localparam int DOY_W  = 9;                          // day of year 1..366

    // Register stages in the date tail after the 400-year divider
    localparam int YMD_TAIL = 5;

    // Cumulative days before each month, non-leap year
    localparam logic [DOY_W-1:0] CUM_DAYS [13] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
        9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
    };

    // Leading dividend bits that are always below the divisor
    function automatic int div_keep(longint unsigned div);
        return $clog2(div + 1) - 1;
    endfunction

    // Remainder width of a constant divider
    function automatic int div_rem_w(longint unsigned div);
        return $clog2(div);
    endfunction

    // Register stages of a constant divider of a w-bit dividend
    function automatic int div_stages(longint unsigned div, int w);
        return (w - div_keep(div) + DIV_BPS - 1) / DIV_BPS;
    endfunction

    // Width of the day count rebased to year 0
    function automatic int zday_w(int days_w);
        return ((days_w > DOFS_W) ? days_w : DOFS_W) + 1;
    endfunction

    // Cycles from an accepted request to its result strobe
    function automatic int ecal_latency(int tw);
        int days_w;
        days_w = tw - div_keep(MS_PER_DAY);
        return 1
            + div_stages(MS_PER_DAY, tw)
            + div_stages(MS_PER_SEC, div_rem_w(MS_PER_DAY))
            + div_stages(SEC_PER_HOUR, SOD_W)
            + div_stages(SEC_PER_MIN, div_rem_w(SEC_PER_HOUR))
            + 1
            + div_stages(DAYS_PER_400Y, zday_w(days_w))
            + YMD_TAIL;
    endfunction

endpackage

[hw/rtl/ecal_cdiv.sv]
// Pipelined restoring divider by a constant, DIV_BPS quotient bits per stage.
// Carries a side payload alongside; depends on ecal_pkg.

module ecal_cdiv
    import ecal_pkg::*;
#(
    parameter int              W   = 27,
    parameter longint unsigned DIV = 1000,
    parameter int              SW  = 1,
    localparam int             QW  = W - div_keep(DIV),
    localparam int             RW  = div_rem_w(DIV)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    input  logic [W-1:0]  i_num,
    input  logic [SW-1:0] i_side,
    output logic          o_vld,
    output logic [QW-1:0] o_quo,
    output logic [RW-1:0] o_rem,
    output logic [SW-1:0] o_side
);

    localparam int KB = div_keep(DIV);
    localparam int NS = div_stages(DIV, W);
    localparam int PW = NS * DIV_BPS;
    localparam int XW = KB + PW;
    localparam logic [RW:0] DV = (RW+1)'(DIV);

    logic [XW-1:0] num_x;

    logic [NS-1:0] r_vld;
    logic [RW-1:0] r_rem  [NS];
    logic [PW-1:0] r_bits [NS];
    logic [PW-1:0] r_quo  [NS];
    logic [SW-1:0] r_side [NS];

    logic [RW-1:0] a_rem  [NS];
    logic [PW-1:0] a_bits [NS];
    logic [PW-1:0] a_quo  [NS];

    logic [RW-1:0] n_rem  [NS];
    logic [PW-1:0] n_bits [NS];
    logic [PW-1:0] n_quo  [NS];

    // leading KB bits are below DIV, so they preload the remainder
    assign num_x = XW'(i_num);

    // stage inputs: request for stage 0, previous stage otherwise
    always_comb begin
        a_rem[0]  = RW'(num_x[XW-1 -: KB]);
        a_bits[0] = num_x[PW-1:0];
        a_quo[0]  = '0;
        for (int s = 1; s < NS; s++) begin
            a_rem[s]  = r_rem[s-1];
            a_bits[s] = r_bits[s-1];
            a_quo[s]  = r_quo[s-1];
        end
    end

    // compare-subtract steps of every stage
    always_comb begin
        logic [RW-1:0] rem;
        logic [RW:0]   tmp;
        logic [PW-1:0] quo;
        for (int s = 0; s < NS; s++) begin
            rem = a_rem[s];
            quo = a_quo[s];
            for (int b = 0; b < DIV_BPS; b++) begin
                tmp = {rem, a_bits[s][PW-1-b]};
                if (tmp >= DV) begin
                    rem = RW'(tmp - DV);
                    quo = {quo[PW-2:0], 1'b1};
                end else begin
                    rem = tmp[RW-1:0];
                    quo = {quo[PW-2:0], 1'b0};
                end
            end
            n_rem[s]  = rem;
            n_quo[s]  = quo;
            n_bits[s] = a_bits[s] << DIV_BPS;
        end
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld[0] <= i_vld;
            for (int s = 1; s < NS; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    // data chain
    always_ff @(posedge i_clk) begin
        r_side[0] <= i_side;
        for (int s = 0; s < NS; s++) begin
            r_rem[s]  <= n_rem[s];
            r_bits[s] <= n_bits[s];
            r_quo[s]  <= n_quo[s];
        end
        for (int s = 1; s < NS; s++) begin
            r_side[s] <= r_side[s-1];
        end
    end

    assign o_vld  = r_vld[NS-1];
    assign o_quo  = r_quo[NS-1][QW-1:0];
    assign o_rem  = r_rem[NS-1];
    assign o_side = r_side[NS-1];

endmodule

[hw/rtl/ecal_ymd.sv]
// Day count since 1970 to year, month and day of month, fully pipelined.
// Depends on ecal_pkg and ecal_cdiv (400-year split).

module ecal_ymd
    import ecal_pkg::*;
#(
    parameter int DW = 24,
    parameter int SW = 27
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  logic [DW-1:0]     i_days,
    input  logic [SW-1:0]     i_side,
    output logic              o_vld,
    output logic [YEAR_W-1:0] o_year,
    output logic [MON_W-1:0]  o_month,
    output logic [MDAY_W-1:0] o_day,
    output logic [SW-1:0]     o_side
);

    localparam int ZW   = zday_w(DW);
    localparam int EQW  = ZW - div_keep(DAYS_PER_400Y);
    localparam int ERW  = div_rem_w(DAYS_PER_400Y);
    localparam int XW   = $clog2(DAYS_PER_100Y + 1);
    localparam int PRW  = 2 * XW;
    localparam int QDW  = 5;
    localparam int DQW  = div_rem_w(DAYS_PER_4Y);

    // rebase to year 0
    logic          r_z_vld;
    logic [ZW-1:0] r_z;
    logic [SW-1:0] r_z_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_z_vld <= 1'b0;
        end else begin
            r_z_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_z      <= ZW'(i_days) + ZW'(DAYS_TO_1970);
        r_z_side <= i_side;
    end

    // 400-year eras
    logic           e_vld;
    logic [EQW-1:0] e_era;
    logic [ERW-1:0] e_d;
    logic [SW-1:0]  e_side;

    ecal_cdiv #(
        .W   (ZW),
        .DIV (DAYS_PER_400Y),
        .SW  (SW)
    ) u_era (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_z_vld),
        .i_num   (r_z),
        .i_side  (r_z_side),
        .o_vld   (e_vld),
        .o_quo   (e_era),
        .o_rem   (e_d),
        .o_side  (e_side)
    );

    // stage A: century within the era, era base year
    logic              r_a_vld;
    logic [YEAR_W-1:0] r_a_ybase;
    logic [1:0]        r_a_cent;
    logic [XW-1:0]     r_a_x;
    logic [SW-1:0]     r_a_side;
    logic [1:0]        n_a_cent;
    logic [XW-1:0]     n_a_x;

    always_comb begin
        logic [ERW-1:0] dm1;
        logic [ERW-1:0] d2;
        dm1 = e_d - ERW'(1);
        if (e_d == '0) begin
            n_a_cent = 2'd0;
        end else if (dm1 >= ERW'(DAYS_PER_100Y * 3)) begin
            n_a_cent = 2'd3;
        end else if (dm1 >= ERW'(DAYS_PER_100Y * 2)) begin
            n_a_cent = 2'd2;
        end else if (dm1 >= ERW'(DAYS_PER_100Y)) begin
            n_a_cent = 2'd1;
        end else begin
            n_a_cent = 2'd0;
        end
        case (n_a_cent)
            2'd1:    d2 = dm1 - ERW'(DAYS_PER_100Y);
            2'd2:    d2 = dm1 - ERW'(DAYS_PER_100Y * 2);
            2'd3:    d2 = dm1 - ERW'(DAYS_PER_100Y * 3);
            default: d2 = dm1;
        endcase
        // day in century, counted from one day earlier in plain centuries
        n_a_x = (n_a_cent != 2'd0) ? XW'(d2 + ERW'(1)) : XW'(e_d);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= e_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_ybase <= YEAR_W'(YEAR_W'(e_era) * YEAR_W'(YEARS_PER_ERA));
        r_a_cent  <= n_a_cent;
        r_a_x     <= n_a_x;
        r_a_side  <= e_side;
    end

    // stage B: reciprocal product for the 4-year block
    logic              r_b_vld;
    logic [PRW-1:0]    r_b_prod;
    logic [XW-1:0]     r_b_x;
    logic              r_b_cent;
    logic [YEAR_W-1:0] r_b_yb;
    logic [SW-1:0]     r_b_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_prod <= PRW'(r_a_x) * PRW'(Q4Y_MUL);
        r_b_x    <= r_a_x;
        r_b_cent <= (r_a_cent != 2'd0);
        r_b_yb   <= r_a_ybase + YEAR_W'(YEAR_W'(r_a_cent) * YEAR_W'(YEARS_PER_CENT));
        r_b_side <= r_a_side;
    end

    // stage C: 4-year block, day within it, leap flag
    logic              r_c_vld;
    logic [QDW-1:0]    r_c_quad;
    logic [DQW-1:0]    r_c_dq;
    logic              r_c_leap;
    logic [YEAR_W-1:0] r_c_yb;
    logic [SW-1:0]     r_c_side;
    logic [QDW-1:0]    n_c_quad;
    logic [DQW-1:0]    n_c_dq;
    logic              n_c_leap;

    always_comb begin
        logic [XW-1:0] rem4;
        n_c_quad = QDW'(r_b_prod >> Q4Y_SHIFT);
        rem4     = r_b_x - XW'(XW'(n_c_quad) * XW'(DAYS_PER_4Y));
        // first block of a plain century has no leap day
        n_c_leap = !(r_b_cent && (n_c_quad == '0));
        n_c_dq   = n_c_leap ? DQW'(rem4) : DQW'(r_b_x - XW'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else begin
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c_quad <= n_c_quad;
        r_c_dq   <= n_c_dq;
        r_c_leap <= n_c_leap;
        r_c_yb   <= r_b_yb;
        r_c_side <= r_b_side;
    end

    // stage D: year within block, day of year, Feb 29
    logic              r_d_vld;
    logic [YEAR_W-1:0] r_d_year;
    logic [DOY_W-1:0]  r_d_doy;
    logic              r_d_feb29;
    logic [SW-1:0]     r_d_side;
    logic [1:0]        n_d_yq;
    logic [DOY_W-1:0]  n_d_doy;
    logic              n_d_feb29;

    always_comb begin
        logic [DQW-1:0] v;
        logic [DOY_W-1:0] doy;
        logic           lead;
        v = r_c_leap ? (r_c_dq - DQW'(1)) : r_c_dq;
        if (r_c_leap && (r_c_dq == '0)) begin
            n_d_yq = 2'd0;
        end else if (v >= DQW'(DAYS_PER_YEAR * 3)) begin
            n_d_yq = 2'd3;
        end else if (v >= DQW'(DAYS_PER_YEAR * 2)) begin
            n_d_yq = 2'd2;
        end else if (v >= DQW'(DAYS_PER_YEAR)) begin
            n_d_yq = 2'd1;
        end else begin
            n_d_yq = 2'd0;
        end
        if (n_d_yq == 2'd0) begin
            doy = DOY_W'(r_c_dq);
        end else begin
            doy = DOY_W'(v - DQW'(DQW'(n_d_yq) * DQW'(DAYS_PER_YEAR)));
        end
        // leading year of a leap block
        lead      = r_c_leap && (n_d_yq == 2'd0);
        n_d_feb29 = lead && (doy == CUM_DAYS[2]);
        if (lead && (doy > CUM_DAYS[2])) begin
            doy = doy - DOY_W'(1);
        end
        n_d_doy = doy + DOY_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else begin
            r_d_vld <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d_year  <= r_c_yb + YEAR_W'(YEAR_W'(r_c_quad) << 2) + YEAR_W'(n_d_yq);
        r_d_doy   <= n_d_doy;
        r_d_feb29 <= n_d_feb29;
        r_d_side  <= r_c_side;
    end

    // stage E: month lookup, output registers
    logic              r_e_vld;
    logic [YEAR_W-1:0] r_e_year;
    logic [MON_W-1:0]  r_e_month;
    logic [MDAY_W-1:0] r_e_day;
    logic [SW-1:0]     r_e_side;
    logic [MON_W-1:0]  n_e_month;
    logic [MDAY_W-1:0] n_e_day;

    always_comb begin
        logic [DOY_W-1:0] base;
        n_e_month = MON_W'(1);
        base      = CUM_DAYS[0];
        for (int k = 1; k < 12; k++) begin
            if (r_d_doy > CUM_DAYS[k]) begin
                n_e_month = MON_W'(k + 1);
                base      = CUM_DAYS[k];
            end
        end
        n_e_day = MDAY_W'(r_d_doy - base);
        if (r_d_feb29) begin
            n_e_month = MON_W'(2);
            n_e_day   = MDAY_W'(29);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
        end else begin
            r_e_vld <= r_d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e_year  <= r_d_year;
        r_e_month <= n_e_month;
        r_e_day   <= n_e_day;
        r_e_side  <= r_d_side;
    end

    assign o_vld   = r_e_vld;
    assign o_year  = r_e_year;
    assign o_month = r_e_month;
    assign o_day   = r_e_day;
    assign o_side  = r_e_side;

endmodule

[hw/rtl/epoch_millis_to_calendar_top.sv]
// Millisecond Unix timestamp to Gregorian date and time of day, top level.
// Depends on ecal_pkg, ecal_cdiv and ecal_ymd.
// Path: request register, day, second, hour and minute dividers, then ecal_ymd, to o_done.
// Throughput: one request per cycle while busy is low; 4 quotient bits per divider stage.
// busy is high in reset, cleared after release; o_done is a one-cycle strobe, no handshake.
// Reset (synchronous, active low) flushes all requests in flight.

module epoch_millis_to_calendar_top
    import ecal_pkg::*;
#(
    parameter int TIME_WIDTH = 50
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [TIME_WIDTH-1:0] i_timestamp_ms,
    output logic                  o_done,
    output logic [YEAR_W-1:0]     o_year,
    output logic [MON_W-1:0]      o_month,
    output logic [MDAY_W-1:0]     o_day,
    output logic [HOUR_W-1:0]     o_hour,
    output logic [MIN_W-1:0]      o_minute,
    output logic [SEC_W-1:0]      o_second,
    output logic [MSEC_W-1:0]     o_millisecond
);

    localparam int DAYS_W = TIME_WIDTH - div_keep(MS_PER_DAY);
    localparam int MSD_W  = div_rem_w(MS_PER_DAY);
    localparam int SQ_W   = MSD_W - div_keep(MS_PER_SEC);
    localparam int HQ_W   = SOD_W - div_keep(SEC_PER_HOUR);
    localparam int SOH_W  = div_rem_w(SEC_PER_HOUR);
    localparam int MQ_W   = SOH_W - div_keep(SEC_PER_MIN);

    // request capture
    logic                  r_busy;
    logic                  r_in_vld;
    logic [TIME_WIDTH-1:0] r_in_ts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b1;
            r_in_vld <= 1'b0;
        end else begin
            r_busy   <= 1'b0;
            r_in_vld <= start && !r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_ts <= i_timestamp_ms;
    end

    assign busy = r_busy;

    // days and millisecond of day
    logic              d_vld;
    logic [DAYS_W-1:0] d_days;
    logic [MSD_W-1:0]  d_msd;

    ecal_cdiv #(
        .W   (TIME_WIDTH),
        .DIV (MS_PER_DAY),
        .SW  (1)
    ) u_day (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_in_vld),
        .i_num   (r_in_ts),
        .i_side  (1'b0),
        .o_vld   (d_vld),
        .o_quo   (d_days),
        .o_rem   (d_msd),
        .o_side  ()
    );

    // second of day and millisecond
    logic              s_vld;
    logic [SQ_W-1:0]   s_sod;
    logic [MSEC_W-1:0] s_ms;
    logic [DAYS_W-1:0] s_days;

    ecal_cdiv #(
        .W   (MSD_W),
        .DIV (MS_PER_SEC),
        .SW  (DAYS_W)
    ) u_sec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (d_vld),
        .i_num   (d_msd),
        .i_side  (d_days),
        .o_vld   (s_vld),
        .o_quo   (s_sod),
        .o_rem   (s_ms),
        .o_side  (s_days)
    );

    // hour and second of hour
    logic                     h_vld;
    logic [HQ_W-1:0]          h_hour;
    logic [SOH_W-1:0]         h_soh;
    logic [DAYS_W+MSEC_W-1:0] h_side;

    ecal_cdiv #(
        .W   (SOD_W),
        .DIV (SEC_PER_HOUR),
        .SW  (DAYS_W + MSEC_W)
    ) u_hour (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (s_vld),
        .i_num   (SOD_W'(s_sod)),
        .i_side  ({s_days, s_ms}),
        .o_vld   (h_vld),
        .o_quo   (h_hour),
        .o_rem   (h_soh),
        .o_side  (h_side)
    );

    // minute and second
    logic                            m_vld;
    logic [MQ_W-1:0]                 m_min;
    logic [SEC_W-1:0]                m_sec;
    logic [DAYS_W+MSEC_W+HOUR_W-1:0] m_side;

    ecal_cdiv #(
        .W   (SOH_W),
        .DIV (SEC_PER_MIN),
        .SW  (DAYS_W + MSEC_W + HOUR_W)
    ) u_min (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (h_vld),
        .i_num   (h_soh),
        .i_side  ({h_side, HOUR_W'(h_hour)}),
        .o_vld   (m_vld),
        .o_quo   (m_min),
        .o_rem   (m_sec),
        .o_side  (m_side)
    );

    // date, time of day rides along
    logic [TOD_W-1:0] y_tod;

    ecal_ymd #(
        .DW (DAYS_W),
        .SW (TOD_W)
    ) u_ymd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (m_vld),
        .i_days  (m_side[DAYS_W+MSEC_W+HOUR_W-1 -: DAYS_W]),
        .i_side  ({m_side[MSEC_W+HOUR_W-1:0], MIN_W'(m_min), m_sec}),
        .o_vld   (o_done),
        .o_year  (o_year),
        .o_month (o_month),
        .o_day   (o_day),
        .o_side  (y_tod)
    );

    assign o_millisecond = y_tod[TOD_W-1 -: MSEC_W];
    assign o_hour        = y_tod[HOUR_W+MIN_W+SEC_W-1 -: HOUR_W];
    assign o_minute      = y_tod[MIN_W+SEC_W-1 -: MIN_W];
    assign o_second      = y_tod[SEC_W-1:0];

endmodule

[hw/rtl/ecal_chk.sv]
// Port-level checker for the epoch-to-calendar top level, bound to it below.
// Depends on ecal_pkg for field widths and pipeline latency.

module ecal_chk
    import ecal_pkg::*;
#(
    parameter int TIME_WIDTH = 50
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  start,
    input logic                  busy,
    input logic                  o_done,
    input logic [YEAR_W-1:0]     o_year,
    input logic [MON_W-1:0]      o_month,
    input logic [MDAY_W-1:0]     o_day,
    input logic [HOUR_W-1:0]     o_hour,
    input logic [MIN_W-1:0]      o_minute,
    input logic [SEC_W-1:0]      o_second,
    input logic [MSEC_W-1:0]     o_millisecond
);

    localparam int LAT = ecal_latency(TIME_WIDTH);

    logic req;
    assign req = start && !busy;

    // every accepted request is answered by a result strobe
    a_req_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req |-> ##LAT o_done)
        else $error("request did not complete after fixed latency");

    // no result without a matching request
    a_done_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(req, LAT))
        else $error("result strobe without a request");

    // reset flushes the pipeline and holds off requests
    a_rst_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_done && busy))
        else $error("reset did not flush the pipeline");

    // calendar and clock fields in range
    a_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_month >= MON_W'(1)) && (o_month <= MON_W'(12))
                && (o_day >= MDAY_W'(1))
                && ((o_month != MON_W'(2)) || (o_day <= MDAY_W'(29)))
                && (o_hour < HOUR_W'(24)) && (o_minute < MIN_W'(60))
                && (o_second < SEC_W'(60)) && (o_millisecond < MSEC_W'(1000)))
        else $error("result field out of range");

endmodule

bind epoch_millis_to_calendar_top ecal_chk #(.TIME_WIDTH(TIME_WIDTH)) u_ecal_chk (.*);

[dv/epoch_millis_to_calendar_tb.sv]
// Self-checking testbench for epoch_millis_to_calendar_top: directed calendar edges and
// random timestamps, checked against a behavioral date/time predictor.
// Depends on ecal_pkg (field widths) and the epoch_millis_to_calendar_top RTL.
`timescale 1ns / 100ps

module tb;
    import ecal_pkg::*;

    localparam int TW           = 50;
    localparam int N_RANDOM     = 1600;
    localparam int IDLE_LIMIT   = 1000;   // cycles with no request and no result
    localparam int DRAIN_CYCLES = 60;     // well past the pipeline latency

    // Calendar constants for the predictor, kept apart from the RTL package
    localparam longint unsigned EPOCH_DAY0 = 64'd719528;   // 0000-01-01 to 1970-01-01
    localparam longint unsigned D400       = 64'd146097;
    localparam longint unsigned D100       = 64'd36524;
    localparam longint unsigned D4         = 64'd1461;
    localparam longint unsigned D1         = 64'd365;
    localparam longint unsigned SEC_DAY    = 64'd86400;
    localparam longint unsigned MS_SEC     = 64'd1000;
    localparam longint unsigned MS_DAY     = 64'd86400000;
    localparam longint unsigned MAR1_TO_EPOCH = 64'd719468;  // 0000-03-01 to 1970-01-01

    localparam int unsigned DAYS_BEFORE_MONTH [13] = '{
        0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365
    };

    typedef struct packed {
        logic [YEAR_W-1:0] year;
        logic [MON_W-1:0]  month;
        logic [MDAY_W-1:0] day;
        logic [HOUR_W-1:0] hour;
        logic [MIN_W-1:0]  minute;
        logic [SEC_W-1:0]  second;
        logic [MSEC_W-1:0] millisecond;
    } cal_t;

    typedef struct {
        logic [TW-1:0] ts;
        cal_t          cal;
    } cal_expect_t;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic [TW-1:0]     i_timestamp_ms = '0;
    logic              busy;
    logic              o_done;
    logic [YEAR_W-1:0] o_year;
    logic [MON_W-1:0]  o_month;
    logic [MDAY_W-1:0] o_day;
    logic [HOUR_W-1:0] o_hour;
    logic [MIN_W-1:0]  o_minute;
    logic [SEC_W-1:0]  o_second;
    logic [MSEC_W-1:0] o_millisecond;

    logic [TW-1:0] ts_pending_q [$];
    int            gap_pending_q [$];
    cal_expect_t   cal_expected_q [$];

    int n_items    = 0;
    int n_directed = 0;
    int n_accepted = 0;
    int n_checked  = 0;
    int err_cnt    = 0;
    int gap_left   = 0;
    int idle_cnt   = 0;

    epoch_millis_to_calendar_top #(
        .TIME_WIDTH(TW)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_timestamp_ms(i_timestamp_ms),
        .o_done        (o_done),
        .o_year        (o_year),
        .o_month       (o_month),
        .o_day         (o_day),
        .o_hour        (o_hour),
        .o_minute      (o_minute),
        .o_second      (o_second),
        .o_millisecond (o_millisecond)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Predicted calendar date and time of day for one timestamp
    function automatic cal_t civil_from_ms(input logic [TW-1:0] ts);
        longint unsigned t, msec, secs, sec_of_day, zday;
        longint unsigned era400, day_in_era, century, quad4, day_in_quad, year_in_quad;
        longint unsigned yr, mon, mday;
        bit has_leap;
        cal_t r;
        t          = ts;
        msec       = t % MS_SEC;
        secs       = t / MS_SEC;
        sec_of_day = secs % SEC_DAY;
        zday       = secs / SEC_DAY + EPOCH_DAY0;

        era400     = zday / D400;
        day_in_era = zday % D400;
        century    = (day_in_era == 0) ? 0 : (day_in_era - 1) / D100;
        has_leap   = 1'b1;

        // Centuries after the first of an era start with a plain 4-year block
        if (century != 0) begin
            day_in_era = (day_in_era - 1) % D100;
            quad4      = (day_in_era + 1) / D4;
            if (quad4 != 0) begin
                day_in_quad = (day_in_era + 1) % D4;
            end else begin
                has_leap    = 1'b0;
                day_in_quad = day_in_era;
            end
        end else begin
            quad4       = day_in_era / D4;
            day_in_quad = day_in_era % D4;
        end

        // First year of a leap block is 366 days long
        if (has_leap) begin
            year_in_quad = (day_in_quad == 0) ? 0 : (day_in_quad - 1) / D1;
            if (year_in_quad != 0)
                day_in_quad = (day_in_quad - 1) % D1;
        end else begin
            year_in_quad = day_in_quad / D1;
            day_in_quad  = day_in_quad % D1;
        end

        yr = era400 * 400 + century * 100 + quad4 * 4 + year_in_quad;

        // Leap day, otherwise month lookup on the non-leap table
        if (year_in_quad == 0 && has_leap && day_in_quad == 59) begin
            mon  = 2;
            mday = 29;
        end else begin
            if (year_in_quad == 0 && has_leap && day_in_quad >= 60)
                day_in_quad--;
            day_in_quad++;
            mon = (day_in_quad >> 5) + 1;
            while (mon < 12 && day_in_quad > DAYS_BEFORE_MONTH[mon])
                mon++;
            mday = day_in_quad - DAYS_BEFORE_MONTH[mon - 1];
        end

        r.year        = YEAR_W'(yr);
        r.month       = MON_W'(mon);
        r.day         = MDAY_W'(mday);
        r.hour        = HOUR_W'(sec_of_day / 3600);
        r.minute      = MIN_W'((sec_of_day / 60) % 60);
        r.second      = SEC_W'(sec_of_day % 60);
        r.millisecond = MSEC_W'(msec);
        return r;
    endfunction

    function automatic bit is_leap(input int unsigned y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int unsigned days_in_month(input int unsigned y, input int unsigned m);
        if (m == 2)
            return is_leap(y) ? 29 : 28;
        return DAYS_BEFORE_MONTH[m] - DAYS_BEFORE_MONTH[m - 1];
    endfunction

    // Timestamp of a calendar date and time, for building stimulus (years >= 1970)
    function automatic logic [TW-1:0] ms_from_civil(
        input longint unsigned y, input longint unsigned mo, input longint unsigned d,
        input longint unsigned h, input longint unsigned mi, input longint unsigned s,
        input longint unsigned ms
    );
        longint unsigned yy, era, yoe, mp, doy, doe, days;
        yy   = (mo <= 2) ? y - 1 : y;
        era  = yy / 400;
        yoe  = yy - era * 400;
        mp   = (mo > 2) ? mo - 3 : mo + 9;
        doy  = (153 * mp + 2) / 5 + d - 1;
        doe  = yoe * 365 + yoe / 4 - yoe / 100 + doy;
        days = era * D400 + doe - MAR1_TO_EPOCH;
        return TW'(days * MS_DAY + h * 3600000 + mi * 60000 + s * 1000 + ms);
    endfunction

    // Mostly short gaps, a few long ones; every third run of 64 goes back to back
    function automatic int pick_gap(input int idx);
        int r;
        if ((idx / 64) % 3 == 0)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic add_item(input logic [TW-1:0] ts);
        ts_pending_q.push_back(ts);
        gap_pending_q.push_back(pick_gap(n_items));
        n_items++;
    endtask

    task automatic check_field(input string fname, input longint unsigned want,
                               input longint unsigned got, input logic [TW-1:0] ts);
        if (want != got) begin
            $display("%0t: %s mismatch for timestamp %0d: expected %0d, got %0d",
                     $time, fname, ts, want, got);
            err_cnt++;
        end
    endtask

    // Driver: present pending requests, hold each until accepted
    always @(posedge i_clk) begin : drv
        bit keep;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            keep = 1'b0;
            if (start && !busy) begin
                cal_expected_q.push_back('{ts: i_timestamp_ms, cal: civil_from_ms(i_timestamp_ms)});
                n_accepted++;
            end else if (start) begin
                keep = 1'b1;
            end
            if (!keep) begin
                if (gap_left > 0) begin
                    gap_left--;
                    start <= 1'b0;
                end else if (ts_pending_q.size() > 0) begin
                    start          <= 1'b1;
                    i_timestamp_ms <= ts_pending_q.pop_front();
                    gap_left        = gap_pending_q.pop_front();
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result strobe with the oldest expectation
    always @(posedge i_clk) begin : mon
        cal_expect_t e;
        if (i_rst_n && o_done) begin
            if (cal_expected_q.size() == 0) begin
                $display("%0t: unexpected result %0d-%0d-%0d %0d:%0d:%0d.%0d",
                         $time, o_year, o_month, o_day, o_hour, o_minute, o_second,
                         o_millisecond);
                err_cnt++;
            end else begin
                e = cal_expected_q.pop_front();
                check_field("year",        e.cal.year,        o_year,        e.ts);
                check_field("month",       e.cal.month,       o_month,       e.ts);
                check_field("day",         e.cal.day,         o_day,         e.ts);
                check_field("hour",        e.cal.hour,        o_hour,        e.ts);
                check_field("minute",      e.cal.minute,      o_minute,      e.ts);
                check_field("second",      e.cal.second,      o_second,      e.ts);
                check_field("millisecond", e.cal.millisecond, o_millisecond, e.ts);
                n_checked++;
            end
        end
    end

    // Watchdog on cycles without any request or result
    always @(posedge i_clk) begin
        if ((i_rst_n && start && !busy) || o_done)
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= IDLE_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
            $display("epoch_millis_to_calendar_top verification failed");
            $finish;
        end
    end

    // Stimulus and end of run
    initial begin
        longint unsigned rnd;
        int unsigned y, mo, d, h, mi, s, ms, dim;
        int sel;

        // Directed: range ends, leap rules at every level, day and year edges
        add_item('0);
        add_item({TW{1'b1}});
        add_item({(TW/2){2'b10}});
        add_item({(TW/2){2'b01}});
        add_item(ms_from_civil(1970, 1, 1, 23, 59, 59, 999));
        add_item(ms_from_civil(1972, 2, 28, 23, 59, 59, 999));
        add_item(ms_from_civil(1972, 2, 29, 12, 0, 0, 0));
        add_item(ms_from_civil(1972, 3, 1, 0, 0, 0, 0));
        add_item(ms_from_civil(1972, 12, 31, 23, 59, 59, 999));
        add_item(ms_from_civil(1973, 1, 1, 0, 0, 0, 0));
        add_item(ms_from_civil(1999, 12, 31, 23, 59, 59, 999));
        add_item(ms_from_civil(2000, 1, 1, 0, 0, 0, 0));
        add_item(ms_from_civil(2000, 2, 29, 6, 30, 30, 500));
        add_item(ms_from_civil(2000, 12, 31, 23, 59, 59, 999));
        add_item(ms_from_civil(2038, 1, 19, 3, 14, 8, 0));
        add_item(ms_from_civil(2100, 2, 28, 23, 59, 59, 999));
        add_item(ms_from_civil(2100, 3, 1, 0, 0, 0, 0));
        add_item(ms_from_civil(2100, 12, 31, 12, 0, 0, 1));
        add_item(ms_from_civil(2103, 12, 31, 23, 59, 59, 999));
        add_item(ms_from_civil(2104, 2, 29, 0, 0, 0, 0));
        add_item(ms_from_civil(2400, 2, 29, 23, 59, 59, 999));
        add_item(ms_from_civil(2400, 12, 31, 23, 59, 59, 999));
        add_item(ms_from_civil(2401, 1, 1, 0, 0, 0, 0));
        add_item(ms_from_civil(37600, 12, 31, 23, 59, 59, 999));
        n_directed = n_items;

        // Random: raw values, dates near calendar edges, plain dates, day boundaries
        for (int i = 0; i < N_RANDOM; i++) begin
            sel = $urandom_range(0, 99);
            if (sel < 35) begin
                rnd = {$urandom(), $urandom()};
                add_item(rnd[TW-1:0]);
            end else begin
                if (sel < 65) begin
                    case ($urandom_range(0, 5))
                        0:       y = $urandom_range(20, 375) * 100;
                        1:       y = $urandom_range(5, 94) * 400;
                        2:       y = $urandom_range(20, 375) * 100 + 1;
                        3:       y = $urandom_range(20, 375) * 100 + 4;
                        4:       y = $urandom_range(20, 375) * 100 - 1;
                        default: y = $urandom_range(493, 9400) * 4;
                    endcase
                end else begin
                    y = $urandom_range(1971, 37600);
                end
                mo  = $urandom_range(1, 12);
                dim = days_in_month(y, mo);
                case ($urandom_range(0, 3))
                    0:       d = 1;
                    1:       d = dim;
                    2:       d = dim - 1;
                    default: d = $urandom_range(1, dim);
                endcase
                case ($urandom_range(0, 2))
                    0: begin h = 0;  mi = 0;  s = 0;  ms = 0;   end
                    1: begin h = 23; mi = 59; s = 59; ms = 999; end
                    default: begin
                        h  = $urandom_range(0, 23);
                        mi = $urandom_range(0, 59);
                        s  = $urandom_range(0, 59);
                        ms = $urandom_range(0, 999);
                    end
                endcase
                if (sel >= 90)
                    add_item(ms_from_civil(y, mo, d, 0, 0, 0, 0) - TW'(1));
                else
                    add_item(ms_from_civil(y, mo, d, h, mi, s, ms));
            end
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_accepted < n_items || cal_expected_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Converted %0d timestamps (%0d directed, %0d random), %0d results checked.",
                 n_accepted, n_directed, n_items - n_directed, n_checked);
        $display("Covered full 50-bit range, leap days, century and 400-year edges, %0d errors.",
                 err_cnt);
        if (err_cnt == 0)
            $display("epoch_millis_to_calendar_top verification clean");
        else
            $display("epoch_millis_to_calendar_top verification failed");
        $finish;
    end

endmodule
